[rtl/dsa_pkg.sv]
`timescale 1ns / 1ps

package dsa_pkg;

    // Request codes
    localparam logic [1:0] ACT_ALLOC = 2'd0;
    localparam logic [1:0] ACT_TAKE  = 2'd1;
    localparam logic [1:0] ACT_DROP  = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_QUOTA   = 2'd1;
    localparam logic [1:0] ST_NOSLOT  = 2'd2;
    localparam logic [1:0] ST_INVALID = 2'd3;

    // Device kinds
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_IDE  = 2'd1;
    localparam logic [1:0] KIND_LOOP = 2'd2;
    localparam logic [1:0] KIND_OBJ  = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_QUOTA_IDE  = 2'd0;
    localparam logic [1:0] CFG_QUOTA_LOOP = 2'd1;
    localparam logic [1:0] CFG_QUOTA_OBJ  = 2'd2;

    localparam int CNT_W = 5;
    localparam logic [CNT_W-1:0] QUOTA_RESET = 5'd16;

    // Control part of the request token that walks the cell chain
    typedef struct packed {
        logic       valid;
        logic [1:0] action;
        logic [1:0] kind;
        logic       hit;
        logic [1:0] status;
        logic       freed;
        logic [1:0] rel_kind;
    } t_dsa_ctl;

endpackage

[rtl/device_slot_allocator_unit.sv]
`timescale 1ns / 1ps
// Path: an allocate, take or drop that reaches the slot table passes through the cell
//   chain, then the staging register and the output register; a request refused up front
//   (bad kind or action, quota full, index out of range) goes straight to the staging register.
// A new request is taken only once the last one has left the cell chain and the staging
//   register; the request token visits one cell per cycle.
// Reset (synchronous, active low): all slots unused with zero references, live counts
//   zero, all quotas 16, no result pending.
module device_slot_allocator_unit #(
    parameter int NUM_SLOTS = 16,
    parameter int REF_BITS  = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,

    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_action,
    input  logic [1:0] i_dev_kind,
    input  logic [3:0] i_slot_index,

    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_status,
    output logic [3:0] o_slot_out,
    output logic [7:0] o_refs_after,
    output logic       o_slot_freed,

    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [4:0] i_cfg_data
);

    localparam int SLOT_W = $clog2(NUM_SLOTS);
    localparam int CW     = dsa_pkg::CNT_W;

    // ------------------------------------------------------------------
    // Configuration: per-kind quotas
    // ------------------------------------------------------------------
    logic [CW-1:0] r_quota_ide, r_quota_loop, r_quota_obj;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quota_ide  <= dsa_pkg::QUOTA_RESET;
            r_quota_loop <= dsa_pkg::QUOTA_RESET;
            r_quota_obj  <= dsa_pkg::QUOTA_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                dsa_pkg::CFG_QUOTA_IDE:  r_quota_ide  <= i_cfg_data;
                dsa_pkg::CFG_QUOTA_LOOP: r_quota_loop <= i_cfg_data;
                dsa_pkg::CFG_QUOTA_OBJ:  r_quota_obj  <= i_cfg_data;
                default:                 r_quota_ide  <= r_quota_ide;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Control flags
    //   r_busy : a token is walking the cell chain
    //   r_pv   : a result sits in the staging register
    //   r_ov   : a result is offered on the output channel
    // ------------------------------------------------------------------
    logic r_busy, r_pv, r_ov;
    logic w_in_xfer, w_out_free;

    // Accept only with no walk in flight and the staging slot empty
    assign o_stall    = r_busy | r_pv;
    assign w_in_xfer  = i_valid & ~o_stall;
    assign w_out_free = ~r_ov | ~i_stall;

    // Live count per kind; entry for the unused kind stays at zero
    logic [CW-1:0] r_live [4];

    // ------------------------------------------------------------------
    // Up-front checks on the incoming request
    // ------------------------------------------------------------------
    logic [CW-1:0]     w_quota;
    logic              w_walk;
    logic [1:0]        w_imm_status;
    logic [3:0]        w_imm_slot;
    logic [SLOT_W+3:0] w_idx_ext;
    logic              w_in_range;

    assign w_idx_ext  = (SLOT_W + 4)'(i_slot_index);
    assign w_in_range = 32'(i_slot_index) < 32'(NUM_SLOTS);

    always_comb begin
        unique case (i_dev_kind)
            dsa_pkg::KIND_IDE:  w_quota = r_quota_ide;
            dsa_pkg::KIND_LOOP: w_quota = r_quota_loop;
            dsa_pkg::KIND_OBJ:  w_quota = r_quota_obj;
            default:            w_quota = '0;
        endcase
    end

    always_comb begin
        w_walk       = 1'b0;
        w_imm_status = dsa_pkg::ST_INVALID;
        w_imm_slot   = '0;
        unique case (i_action)
            dsa_pkg::ACT_ALLOC: begin
                // refuse a kind of none, then a kind at its quota
                if (i_dev_kind == dsa_pkg::KIND_NONE) begin
                    w_imm_status = dsa_pkg::ST_INVALID;
                end else if (r_live[i_dev_kind] >= w_quota) begin
                    w_imm_status = dsa_pkg::ST_QUOTA;
                end else begin
                    w_walk = 1'b1;
                end
            end
            dsa_pkg::ACT_TAKE, dsa_pkg::ACT_DROP: begin
                w_imm_slot = i_slot_index;
                w_walk     = w_in_range;
            end
            default: begin
                w_imm_status = dsa_pkg::ST_INVALID;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Cell chain: one cell per slot, the token advances one cell a cycle
    // ------------------------------------------------------------------
    dsa_pkg::t_dsa_ctl   w_ctl  [NUM_SLOTS+1];
    logic [SLOT_W-1:0]   w_tgt  [NUM_SLOTS+1];
    logic [SLOT_W-1:0]   w_slot [NUM_SLOTS+1];
    logic [REF_BITS-1:0] w_refs [NUM_SLOTS+1];
    dsa_pkg::t_dsa_ctl   w_head_ctl;

    always_comb begin
        w_head_ctl          = '0;
        w_head_ctl.valid    = w_in_xfer & w_walk;
        w_head_ctl.action   = i_action;
        w_head_ctl.kind     = i_dev_kind;
        w_head_ctl.hit      = 1'b0;
        // status if no cell claims the token
        w_head_ctl.status   = (i_action == dsa_pkg::ACT_ALLOC) ? dsa_pkg::ST_NOSLOT
                                                              : dsa_pkg::ST_INVALID;
        w_head_ctl.freed    = 1'b0;
        w_head_ctl.rel_kind = dsa_pkg::KIND_NONE;
    end

    assign w_ctl[0]  = w_head_ctl;
    assign w_tgt[0]  = w_idx_ext[SLOT_W-1:0];
    assign w_slot[0] = (i_action == dsa_pkg::ACT_ALLOC) ? '0 : w_idx_ext[SLOT_W-1:0];
    assign w_refs[0] = '0;

    for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
        dsa_cell #(
            .SLOT_W   (SLOT_W),
            .REF_BITS (REF_BITS),
            .CELL_ID  (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl[g]),
            .i_tgt   (w_tgt[g]),
            .i_slot  (w_slot[g]),
            .i_refs  (w_refs[g]),
            .o_ctl   (w_ctl[g+1]),
            .o_tgt   (w_tgt[g+1]),
            .o_slot  (w_slot[g+1]),
            .o_refs  (w_refs[g+1])
        );
    end

    dsa_pkg::t_dsa_ctl w_end;
    logic [SLOT_W+3:0]   w_end_slot_ext;
    logic [REF_BITS+7:0] w_end_refs_ext;

    assign w_end          = w_ctl[NUM_SLOTS];
    assign w_end_slot_ext = (SLOT_W + 4)'(w_slot[NUM_SLOTS]);
    assign w_end_refs_ext = (REF_BITS + 8)'(w_refs[NUM_SLOTS]);

    // ------------------------------------------------------------------
    // Walk flag and live counts, updated as the token leaves the chain
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            for (int k = 0; k < 4; k++) begin
                r_live[k] <= '0;
            end
        end else begin
            if (w_in_xfer && w_walk) begin
                r_busy <= 1'b1;
            end else if (w_end.valid) begin
                r_busy <= 1'b0;
            end
            if (w_end.valid) begin
                // bump on a granted allocate, drop on a release, never below zero
                if (w_end.action == dsa_pkg::ACT_ALLOC && w_end.hit) begin
                    r_live[w_end.kind] <= CW'(r_live[w_end.kind] + 1'b1);
                end else if (w_end.freed && r_live[w_end.rel_kind] != '0) begin
                    r_live[w_end.rel_kind] <= CW'(r_live[w_end.rel_kind] - 1'b1);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Staging register, then output register
    // ------------------------------------------------------------------
    logic [1:0] r_p_status, r_o_status;
    logic [3:0] r_p_slot,   r_o_slot;
    logic [7:0] r_p_refs,   r_o_refs;
    logic       r_p_freed,  r_o_freed;
    logic       w_drain;

    assign w_drain = r_pv & w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if ((w_in_xfer && !w_walk) || w_end.valid) begin
                r_pv <= 1'b1;
            end else if (w_drain) begin
                r_pv <= 1'b0;
            end
            if (w_out_free) begin
                r_ov <= r_pv;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        // refused up front: no state change
        if (w_in_xfer && !w_walk) begin
            r_p_status <= w_imm_status;
            r_p_slot   <= w_imm_slot;
            r_p_refs   <= '0;
            r_p_freed  <= 1'b0;
        end else if (w_end.valid) begin
            r_p_status <= w_end.status;
            r_p_slot   <= w_end_slot_ext[3:0];
            r_p_refs   <= w_end_refs_ext[7:0];
            r_p_freed  <= w_end.freed;
        end
        if (w_drain) begin
            r_o_status <= r_p_status;
            r_o_slot   <= r_p_slot;
            r_o_refs   <= r_p_refs;
            r_o_freed  <= r_p_freed;
        end
    end

    assign o_valid      = r_ov;
    assign o_status     = r_o_status;
    assign o_slot_out   = r_o_slot;
    assign o_refs_after = r_o_refs;
    assign o_slot_freed = r_o_freed;

endmodule

[rtl/dsa_cell.sv]
`timescale 1ns / 1ps

module dsa_cell #(
    parameter int SLOT_W   = 4,
    parameter int REF_BITS = 8,
    parameter int CELL_ID  = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  dsa_pkg::t_dsa_ctl    i_ctl,
    input  logic [SLOT_W-1:0]    i_tgt,
    input  logic [SLOT_W-1:0]    i_slot,
    input  logic [REF_BITS-1:0]  i_refs,
    output dsa_pkg::t_dsa_ctl    o_ctl,
    output logic [SLOT_W-1:0]    o_tgt,
    output logic [SLOT_W-1:0]    o_slot,
    output logic [REF_BITS-1:0]  o_refs
);

    localparam logic [SLOT_W-1:0] MY_ID = SLOT_W'(CELL_ID);

    logic [1:0]          r_kind, n_kind;
    logic [REF_BITS-1:0] r_refs, n_refs;

    dsa_pkg::t_dsa_ctl   r_ctl, n_ctl;
    logic [SLOT_W-1:0]   r_tgt, r_slot, n_slot;
    logic [REF_BITS-1:0] r_tok_refs, n_tok_refs;

    always_comb begin
        n_kind     = r_kind;
        n_refs     = r_refs;
        n_ctl      = i_ctl;
        n_slot     = i_slot;
        n_tok_refs = i_refs;
        if (i_ctl.valid && !i_ctl.hit) begin
            unique case (i_ctl.action)
                dsa_pkg::ACT_ALLOC: begin
                    // claim this slot if it is the first free one seen
                    if (r_kind == dsa_pkg::KIND_NONE) begin
                        n_ctl.hit    = 1'b1;
                        n_ctl.status = dsa_pkg::ST_OK;
                        n_slot       = MY_ID;
                        n_tok_refs   = REF_BITS'(1);
                        n_kind       = i_ctl.kind;
                        n_refs       = REF_BITS'(1);
                    end
                end
                dsa_pkg::ACT_TAKE: begin
                    if (i_tgt == MY_ID) begin
                        n_ctl.hit  = 1'b1;
                        n_tok_refs = r_refs;
                        if (r_kind != dsa_pkg::KIND_NONE && r_refs != '0 && r_refs != '1) begin
                            n_ctl.status = dsa_pkg::ST_OK;
                            n_tok_refs   = REF_BITS'(r_refs + 1'b1);
                            n_refs       = REF_BITS'(r_refs + 1'b1);
                        end
                    end
                end
                dsa_pkg::ACT_DROP: begin
                    if (i_tgt == MY_ID) begin
                        n_ctl.hit  = 1'b1;
                        n_tok_refs = r_refs;
                        if (r_kind != dsa_pkg::KIND_NONE && r_refs != '0) begin
                            n_ctl.status = dsa_pkg::ST_OK;
                            n_tok_refs   = REF_BITS'(r_refs - 1'b1);
                            n_refs       = REF_BITS'(r_refs - 1'b1);
                            if (r_refs == REF_BITS'(1)) begin
                                n_ctl.freed    = 1'b1;
                                n_ctl.rel_kind = r_kind;
                                n_kind         = dsa_pkg::KIND_NONE;
                            end
                        end
                    end
                end
                default: begin
                    n_ctl.hit = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind      <= dsa_pkg::KIND_NONE;
            r_refs      <= '0;
            r_ctl.valid <= 1'b0;
        end else begin
            r_kind      <= n_kind;
            r_refs      <= n_refs;
            r_ctl.valid <= n_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ctl.action   <= n_ctl.action;
        r_ctl.kind     <= n_ctl.kind;
        r_ctl.hit      <= n_ctl.hit;
        r_ctl.status   <= n_ctl.status;
        r_ctl.freed    <= n_ctl.freed;
        r_ctl.rel_kind <= n_ctl.rel_kind;
        r_tgt          <= i_tgt;
        r_slot         <= n_slot;
        r_tok_refs     <= n_tok_refs;
    end

    assign o_ctl  = r_ctl;
    assign o_tgt  = r_tgt;
    assign o_slot = r_slot;
    assign o_refs = r_tok_refs;

endmodule

[rtl/dsa_checker.sv]
`timescale 1ns / 1ps

module dsa_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [1:0] o_status,
    input logic [3:0] o_slot_out,
    input logic [7:0] o_refs_after,
    input logic       o_slot_freed
);

    // One item in flight: an input transfer closes the input side next cycle
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input taken while a request was still open");

    // Stalled result holds
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid &&
            $stable({o_status, o_slot_out, o_refs_after, o_slot_freed})))
        else $error("stalled result changed");

    // A release is a successful drop to zero references
    a_freed_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_slot_freed) |-> (o_status == dsa_pkg::ST_OK && o_refs_after == 8'd0))
        else $error("slot freed without a good drop to zero");

    // Refused allocate reports nothing
    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == dsa_pkg::ST_QUOTA || o_status == dsa_pkg::ST_NOSLOT))
        |-> (o_slot_out == 4'd0 && o_refs_after == 8'd0 && !o_slot_freed))
        else $error("refused allocate carries slot data");

endmodule

bind device_slot_allocator_unit dsa_checker u_dsa_checker (.*);
